@@ hdl/gsm_pkg.sv @@
// Shared types and constants of the golden-section minimizer.
// Holds the controller states, the command and status structs and the register indexes.
// Used by every module of the block; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package gsm_pkg;

  localparam int ITER_BITS = 10;
  localparam int CFG_IDX_W = 3;
  localparam int GOLD_W    = 32;

  // (3 - sqrt(5)) / 2 as an unsigned Q0.32 fraction.
  localparam logic [GOLD_W-1:0] GOLD_Q32 = 32'd1640531527;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_QUAD  = 3'd0,
    CFG_LIN   = 3'd1,
    CFG_CONST = 3'd2,
    CFG_TOL   = 3'd3,
    CFG_ITER  = 3'd4
  } cfg_idx_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_OFFSET,
    ST_PROBE,
    ST_CHECK,
    ST_DECIDE,
    ST_FINISH
  } gsm_state_t;

  typedef struct packed {
    logic load_in;
    logic mul_offset;
    logic mul_slope;
    logic set_probes;
    logic shrink;
    logic load_out;
  } gsm_cmd_t;

  typedef struct packed {
    logic stop;
  } gsm_stat_t;

endpackage

`default_nettype wire

@@ hdl/gsm_cfg.sv @@
// Configuration register file of the golden-section minimizer.
// Decodes writes on the configuration channel into the objective and stop registers.
// Depends on gsm_pkg for the register indexes and the iteration width.
`timescale 1ns / 1ps
`default_nettype none

module gsm_cfg
  import gsm_pkg::*;
#(
  parameter int DATA_WIDTH = 32,
  parameter int FRAC_BITS  = 16
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         cfg_valid,
  output logic                              cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]         cfg_index,
  input  wire logic [DATA_WIDTH-1:0]        cfg_data,
  output logic signed [DATA_WIDTH-1:0]      quad_coeff,
  output logic signed [DATA_WIDTH-1:0]      lin_coeff,
  output logic [DATA_WIDTH-2:0]             tolerance,
  output logic [ITER_BITS-1:0]              max_iter
);

  localparam logic signed [DATA_WIDTH-1:0] QUAD_RST = DATA_WIDTH'(2 <<< FRAC_BITS);
  localparam logic signed [DATA_WIDTH-1:0] LIN_RST  = DATA_WIDTH'(-6 <<< FRAC_BITS);
  localparam logic [DATA_WIDTH-2:0]        TOL_RST  = (DATA_WIDTH-1)'(655);
  localparam logic [ITER_BITS-1:0]         ITER_RST = ITER_BITS'(64);

  logic signed [DATA_WIDTH-1:0] quad_r;
  logic signed [DATA_WIDTH-1:0] lin_r;
  logic [DATA_WIDTH-2:0]        tol_r;
  logic [ITER_BITS-1:0]         iter_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      quad_r <= QUAD_RST;
      lin_r  <= LIN_RST;
      tol_r  <= TOL_RST;
      iter_r <= ITER_RST;
    end else if (cfg_valid) begin
      case (cfg_idx_t'(cfg_index))
        CFG_QUAD: quad_r <= cfg_data;
        CFG_LIN:  lin_r  <= cfg_data;
        // The constant term never moves the minimizer, so it is not stored.
        CFG_CONST: ;
        CFG_TOL:  tol_r  <= cfg_data[DATA_WIDTH-2:0];
        CFG_ITER: iter_r <= cfg_data[ITER_BITS-1:0];
        default: ;
      endcase
    end
  end

  assign quad_coeff = quad_r;
  assign lin_coeff  = lin_r;
  assign tolerance  = tol_r;
  assign max_iter   = iter_r;

endmodule

`default_nettype wire

@@ hdl/gsm_ctrl.sv @@
// Controller state machine of the golden-section minimizer.
// Sequences offset, probe setup and the check/decide loop, and owns the result valid flag.
// Depends on gsm_pkg for the state enum and the command and status structs.
`timescale 1ns / 1ps
`default_nettype none

module gsm_ctrl
  import gsm_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic in_valid,
  output logic      in_ready,
  output logic      out_valid,
  input  wire logic out_ready,
  input  wire gsm_stat_t stat,
  output gsm_cmd_t  cmd
);

  gsm_state_t state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       out_free;

  assign out_free = !out_valid_r || out_ready;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:   if (in_valid) state_nxt = ST_OFFSET;
      ST_OFFSET: state_nxt = ST_PROBE;
      ST_PROBE:  state_nxt = ST_CHECK;
      ST_CHECK:  state_nxt = stat.stop ? ST_FINISH : ST_DECIDE;
      ST_DECIDE: state_nxt = ST_CHECK;
      ST_FINISH: if (out_free) state_nxt = ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    case (state_r)
      ST_IDLE:   cmd.load_in    = in_valid;
      ST_OFFSET: cmd.mul_offset = 1'b1;
      ST_PROBE:  cmd.set_probes = 1'b1;
      ST_CHECK:  cmd.mul_slope  = !stat.stop;
      ST_DECIDE: cmd.shrink     = 1'b1;
      ST_FINISH: cmd.load_out   = out_free;
      default:   cmd = '0;
    endcase
  end

  always_comb begin
    if (cmd.load_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;

endmodule

`default_nettype wire

@@ hdl/gsm_dp.sv @@
// Datapath of the golden-section minimizer.
// Holds the interval, both probes, the step counter, the shared multiplier and the result.
// Depends on gsm_pkg for the command and status structs and the golden-ratio constant.
`timescale 1ns / 1ps
`default_nettype none

module gsm_dp
  import gsm_pkg::*;
#(
  parameter int DATA_WIDTH = 32,
  parameter int FRAC_BITS  = 16
) (
  input  wire logic                          clk,
  input  wire gsm_cmd_t                      cmd,
  output gsm_stat_t                          stat,
  input  wire logic signed [DATA_WIDTH-1:0]  in_left_end,
  input  wire logic signed [DATA_WIDTH-1:0]  in_right_end,
  input  wire logic signed [DATA_WIDTH-1:0]  quad_coeff,
  input  wire logic signed [DATA_WIDTH-1:0]  lin_coeff,
  input  wire logic [DATA_WIDTH-2:0]         tolerance,
  input  wire logic [ITER_BITS-1:0]          max_iter,
  output logic signed [DATA_WIDTH-1:0]       out_minimizer,
  output logic [ITER_BITS-1:0]               out_steps_done,
  output logic                               out_converged
);

  localparam int DW  = DATA_WIDTH;
  localparam int AW  = DW + 2;
  localparam int BW  = ((DW > GOLD_W) ? DW : GOLD_W) + 1;
  localparam int PW  = AW + BW;
  localparam int CW  = DW + FRAC_BITS + 1;
  localparam int SW  = ((PW > CW) ? PW : CW) + 1;

  logic signed [DW-1:0]     lo_r, hi_r, x_r, y_r;
  logic [ITER_BITS-1:0]     steps_r;
  logic signed [PW-1:0]     prod_r;
  logic signed [DW-1:0]     min_r;
  logic [ITER_BITS-1:0]     steps_out_r;
  logic                     conv_r;

  logic signed [DW:0]       width_s;
  logic [DW:0]              width_mag;
  logic                     narrow;
  logic [ITER_BITS:0]       next_count;
  logic signed [DW:0]       probe_sum;
  logic signed [AW-1:0]     mul_a;
  logic signed [BW-1:0]     mul_b;
  logic [DW-1:0]            offset;
  logic signed [DW-1:0]     x_init;
  logic signed [SW-1:0]     slope_sum;
  logic                     slope_pos, slope_neg, left_smaller;
  logic signed [DW:0]       bound_sum;

  assign width_s   = {hi_r[DW-1], hi_r} - {lo_r[DW-1], lo_r};
  assign width_mag = width_s[DW] ? $unsigned(-width_s) : $unsigned(width_s);
  assign narrow    = width_mag < {1'b0, tolerance, 1'b0};

  assign next_count = {1'b0, steps_r} + (ITER_BITS+1)'(1);
  assign stat.stop  = narrow || !(next_count < {1'b0, max_iter});

  assign probe_sum = {x_r[DW-1], x_r} + {y_r[DW-1], y_r};

  always_comb begin
    if (cmd.mul_offset) begin
      mul_a = $signed({1'b0, width_mag});
      mul_b = $signed({{(BW-GOLD_W){1'b0}}, GOLD_Q32});
    end else begin
      mul_a = $signed({probe_sum[DW], probe_sum});
      mul_b = $signed({{(BW-DW){quad_coeff[DW-1]}}, quad_coeff});
    end
  end

  // Rounded offset: the product is in Q0.32 units, bit 31 rounds half up.
  assign offset = prod_r[DW+GOLD_W-1:GOLD_W] + DW'(prod_r[GOLD_W-1]);
  assign x_init = width_s[DW] ? (lo_r - $signed(offset)) : (lo_r + $signed(offset));

  assign slope_sum = SW'(prod_r) + (SW'(lin_coeff) <<< FRAC_BITS);
  assign slope_neg = slope_sum[SW-1];
  assign slope_pos = !slope_sum[SW-1] && (slope_sum != '0);
  assign left_smaller = ((x_r < y_r) && slope_pos) || ((x_r > y_r) && slope_neg);

  assign bound_sum = {lo_r[DW-1], lo_r} + {hi_r[DW-1], hi_r};

  always_ff @(posedge clk) begin
    if (cmd.mul_offset || cmd.mul_slope) begin
      prod_r <= mul_a * mul_b;
    end
    if (cmd.load_in) begin
      lo_r    <= in_left_end;
      hi_r    <= in_right_end;
      steps_r <= '0;
    end else if (cmd.set_probes) begin
      x_r <= x_init;
      y_r <= lo_r + hi_r - x_init;
    end else if (cmd.shrink) begin
      steps_r <= steps_r + ITER_BITS'(1);
      if (left_smaller) begin
        hi_r <= y_r;
        y_r  <= x_r;
        x_r  <= lo_r + y_r - x_r;
      end else begin
        lo_r <= x_r;
        x_r  <= y_r;
        y_r  <= x_r + hi_r - y_r;
      end
    end
    if (cmd.load_out) begin
      min_r       <= bound_sum[DW:1];
      steps_out_r <= steps_r;
      conv_r      <= narrow;
    end
  end

  assign out_minimizer  = min_r;
  assign out_steps_done = steps_out_r;
  assign out_converged  = conv_r;

endmodule

`default_nettype wire

@@ hdl/golden_section_minimizer_top.sv @@
// Top level of the golden-section minimizer of a quadratic objective.
// Joins the configuration registers, the controller and the datapath.
// Depends on gsm_pkg, gsm_cfg, gsm_ctrl and gsm_dp.
//
// An item on the input channel gives an interval [left_end, right_end] in signed
// fixed point. The block searches it for the minimizer of the quadratic set by
// the configuration registers and returns one result item: the midpoint of the
// final interval, the number of shrink steps and a converged flag.
// The configuration channel is always ready; write it only while the block is idle.
// After an accept the controller passes through the offset and probe states, then
// loops check and decide once per shrink step: in check the shared multiplier forms
// the slope product, and in decide the interval is compared and shrunk. When check
// finds the stop condition, the finish state loads the result.
// One item is searched at a time; the next item is taken once the search ends,
// while the previous result may still be waiting in the output register.
// If the receiver stalls, the result holds and a finished search waits for the
// output register to empty before the block takes another item.
// Reset clears the controller and restores the register defaults.
`timescale 1ns / 1ps
`default_nettype none

module golden_section_minimizer_top
  import gsm_pkg::*;
#(
  parameter int DATA_WIDTH = 32,
  parameter int FRAC_BITS  = 16
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic signed [DATA_WIDTH-1:0]  in_left_end,
  input  wire logic signed [DATA_WIDTH-1:0]  in_right_end,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic signed [DATA_WIDTH-1:0]       out_minimizer,
  output logic [ITER_BITS-1:0]               out_steps_done,
  output logic                               out_converged,
  input  wire logic                          cfg_valid,
  output logic                               cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]          cfg_index,
  input  wire logic [DATA_WIDTH-1:0]         cfg_data
);

  logic signed [DATA_WIDTH-1:0] quad_coeff;
  logic signed [DATA_WIDTH-1:0] lin_coeff;
  logic [DATA_WIDTH-2:0]        tolerance;
  logic [ITER_BITS-1:0]         max_iter;
  gsm_cmd_t                     cmd;
  gsm_stat_t                    stat;

  gsm_cfg #(
    .DATA_WIDTH (DATA_WIDTH),
    .FRAC_BITS  (FRAC_BITS)
  ) u_cfg (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .quad_coeff (quad_coeff),
    .lin_coeff  (lin_coeff),
    .tolerance  (tolerance),
    .max_iter   (max_iter)
  );

  gsm_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  gsm_dp #(
    .DATA_WIDTH (DATA_WIDTH),
    .FRAC_BITS  (FRAC_BITS)
  ) u_dp (
    .clk            (clk),
    .cmd            (cmd),
    .stat           (stat),
    .in_left_end    (in_left_end),
    .in_right_end   (in_right_end),
    .quad_coeff     (quad_coeff),
    .lin_coeff      (lin_coeff),
    .tolerance      (tolerance),
    .max_iter       (max_iter),
    .out_minimizer  (out_minimizer),
    .out_steps_done (out_steps_done),
    .out_converged  (out_converged)
  );

  // An accepted item keeps the block busy in the next cycle.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("input accepted again right after an accept");

  // A new result appears only at the end of a search, never out of idle.
  a_result_from_search: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.load_out) |-> !in_ready)
    else $error("result loaded while the controller was idle");

  // Shrinking and loading a result never happen in the same cycle.
  a_cmd_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.load_in, cmd.mul_offset, cmd.set_probes, cmd.shrink, cmd.load_out}))
    else $error("conflicting datapath commands");

  // A probe setup is always followed by a loop check.
  a_probe_then_check: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.set_probes |=> !(cmd.shrink || cmd.set_probes || cmd.load_in))
    else $error("probe setup not followed by a loop check");

endmodule

`default_nettype wire

@@ tb/tb_golden_section_minimizer_top.sv @@
// Testbench for golden_section_minimizer_top: predicts every search result and checks it.
// Drives intervals and register writes with random idling and back-pressure.
// Depends on gsm_pkg and the golden_section_minimizer_top RTL.
`timescale 1ns / 1ps

module tb_golden_section_minimizer_top;
  import gsm_pkg::*;

  localparam int CYCLE_LIMIT = 6000000;
  localparam int HOLD_CYCLES = 400;

  typedef struct packed {
    logic signed [31:0]    minimizer;
    logic [ITER_BITS-1:0]  steps_done;
    logic                  converged;
  } search_outcome_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  logic signed [31:0]    in_left_end = '0;
  logic signed [31:0]    in_right_end = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic signed [31:0]    out_minimizer;
  logic [ITER_BITS-1:0]  out_steps_done;
  logic                  out_converged;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = CFG_QUAD;
  logic [31:0]           cfg_data = '0;

  logic signed [31:0]    obj_quad = 32'sd131072;
  logic signed [31:0]    obj_lin = -32'sd393216;
  logic [30:0]           obj_tol = 31'd655;
  logic [ITER_BITS-1:0]  obj_iter = 10'd64;

  search_outcome_t       pending_outcomes[$];
  search_outcome_t       head_outcome;
  int                    mismatches = 0;
  int                    cycle_count = 0;
  logic                  steady = 1'b0;
  logic [7:0]            hold_token = '0;
  logic [7:0]            hold_seen = '0;
  int                    hold_left = 0;

  golden_section_minimizer_top u_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_left_end    (in_left_end),
    .in_right_end   (in_right_end),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_minimizer  (out_minimizer),
    .out_steps_done (out_steps_done),
    .out_converged  (out_converged),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data)
  );

  always #5 clk = ~clk;

  function automatic longint wrap32(input longint v);
    logic signed [31:0] t;
    t = v[31:0];
    return t;
  endfunction

  function automatic longint unsigned magnitude(input longint v);
    return (v < 0) ? -v : v;
  endfunction

  function automatic logic width_below_tol(input longint lo, input longint hi);
    longint unsigned twice_tol;
    twice_tol = {33'd0, obj_tol} << 1;
    return magnitude(hi - lo) < twice_tol;
  endfunction

  // Exact comparison of f(x) < f(y) through the sign of the slope term.
  function automatic logic left_probe_lower(input longint x, input longint y);
    logic signed [127:0] c2, c1, sum, slope;
    c2 = obj_quad;
    c1 = obj_lin;
    sum = x + y;
    slope = c2 * sum + (c1 <<< 16);
    return ((x < y) && (slope > 0)) || ((x > y) && (slope < 0));
  endfunction

  function automatic search_outcome_t golden_search(input logic signed [31:0] left,
                                                    input logic signed [31:0] right);
    longint           lo, hi, x, y, w, off, mid;
    logic [127:0]     prod;
    int unsigned      n, steps;
    search_outcome_t  res;
    lo = left;
    hi = right;
    w = hi - lo;
    prod = 128'(magnitude(w)) * 128'(GOLD_Q32);
    off = prod[95:32] + prod[31];
    x = wrap32((w < 0) ? lo - off : lo + off);
    y = wrap32(lo + hi - x);
    steps = 0;
    for (n = 1; n < obj_iter; n++) begin
      if (width_below_tol(lo, hi)) break;
      if (left_probe_lower(x, y)) begin
        hi = y;
        y = x;
        x = wrap32(lo + hi - y);
      end else begin
        lo = x;
        x = y;
        y = wrap32(lo + hi - x);
      end
      steps++;
    end
    mid = (lo + hi) >>> 1;
    res.minimizer = mid[31:0];
    res.steps_done = steps[ITER_BITS-1:0];
    res.converged = width_below_tol(lo, hi);
    return res;
  endfunction

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (hold_token != hold_seen) begin
      hold_seen <= hold_token;
      hold_left <= HOLD_CYCLES;
      out_ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= steady || ($urandom_range(99) >= 28);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (pending_outcomes.size() == 0) begin
        $display("%0t: result with none expected, minimizer %0d steps %0d converged %0b",
                 $time, out_minimizer, out_steps_done, out_converged);
        mismatches++;
      end else begin
        head_outcome = pending_outcomes.pop_front();
        if (out_minimizer !== head_outcome.minimizer) begin
          $display("%0t: minimizer expected %0d actual %0d", $time,
                   $signed(head_outcome.minimizer), out_minimizer);
          mismatches++;
        end
        if (out_steps_done !== head_outcome.steps_done) begin
          $display("%0t: steps_done expected %0d actual %0d", $time,
                   head_outcome.steps_done, out_steps_done);
          mismatches++;
        end
        if (out_converged !== head_outcome.converged) begin
          $display("%0t: converged expected %0b actual %0b", $time,
                   head_outcome.converged, out_converged);
          mismatches++;
        end
      end
    end
  end

  task automatic send_interval(input logic signed [31:0] left, input logic signed [31:0] right);
    if (!steady) begin
      while ($urandom_range(99) < 28) begin
        in_valid <= 1'b0;
        @(posedge clk);
      end
    end
    in_valid <= 1'b1;
    in_left_end <= left;
    in_right_end <= right;
    do @(posedge clk); while (!in_ready);
    pending_outcomes.push_back(golden_search(left, right));
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_outcomes.size() != 0);
  endtask

  task automatic write_reg(input cfg_idx_t idx, input logic [31:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      CFG_QUAD:  obj_quad = value;
      CFG_LIN:   obj_lin = value;
      CFG_CONST: ;
      CFG_TOL:   obj_tol = value[30:0];
      CFG_ITER:  obj_iter = value[ITER_BITS-1:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic random_interval(output logic signed [31:0] left,
                                 output logic signed [31:0] right);
    int unsigned pick;
    pick = $urandom_range(9);
    if (pick <= 2) begin
      left = $urandom;
      right = $urandom;
    end else if (pick <= 5) begin
      left = int'($urandom_range(0, 1 << 23)) - (1 << 22);
      right = left + int'($urandom_range(0, 1 << 21)) - (1 << 19);
    end else if (pick <= 7) begin
      left = $urandom;
      right = left + int'($urandom_range(0, 1 << 12));
    end else if (pick == 8) begin
      left = $urandom;
      right = left + int'($urandom_range(0, 6)) - 3;
    end else begin
      case ($urandom_range(3))
        0: left = 32'sh8000_0000;
        1: left = 32'sh7fff_ffff;
        2: left = 32'sd0;
        default: left = $urandom;
      endcase
      right = ($urandom_range(1) == 1) ? 32'sh7fff_ffff : 32'sh8000_0000;
    end
  endtask

  task automatic randomize_objective(output int unsigned item_count);
    logic [31:0] value;
    case ($urandom_range(3))
      0: value = $urandom_range(1, 1 << 18);
      1: value = -int'($urandom_range(1, 1 << 18));
      2: value = $urandom;
      default: value = ($urandom_range(1) == 1) ? 32'd131072 : 32'd0;
    endcase
    write_reg(CFG_QUAD, value);
    value = ($urandom_range(1) == 1) ? $urandom
                                     : int'($urandom_range(0, 1 << 21)) - (1 << 20);
    write_reg(CFG_LIN, value);
    write_reg(CFG_CONST, $urandom);
    case ($urandom_range(9))
      0:       value = 32'd0;
      1, 2:    value = $urandom_range(0, 1 << 20);
      3:       value = $urandom >> 1;
      default: value = $urandom_range(0, 4095);
    endcase
    write_reg(CFG_TOL, value);
    value = ($urandom_range(7) == 0) ? $urandom_range(81, 1023) : $urandom_range(0, 80);
    write_reg(CFG_ITER, value);
    item_count = (value > 200) ? 8 : 55;
  endtask

  task automatic test_default_objective();
    send_interval(-32'sd196608, 32'sd655360);
    send_interval(32'sd0, 32'sd0);
    send_interval(32'sh8000_0000, 32'sh7fff_ffff);
    send_interval(32'sh7fff_ffff, 32'sh8000_0000);
    send_interval(32'sd98304, 32'sd98304);
    send_interval(32'sd655360, -32'sd196608);
    send_interval(32'sh8000_0000, 32'sh8000_0000);
    send_interval(32'sh7fff_ffff, 32'sh7fff_ffff);
    send_interval(-32'sd1, 32'sd0);
    wait_drained();
  endtask

  task automatic test_step_limits();
    write_reg(CFG_ITER, 32'd0);
    send_interval(-32'sd196608, 32'sd655360);
    wait_drained();
    write_reg(CFG_ITER, 32'd1);
    send_interval(32'sh8000_0000, 32'sh7fff_ffff);
    wait_drained();
    write_reg(CFG_ITER, 32'd2);
    send_interval(32'sd655360, -32'sd196608);
    wait_drained();
    write_reg(CFG_TOL, 32'd0);
    write_reg(CFG_ITER, 32'd1023);
    send_interval(32'sh8000_0000, 32'sh7fff_ffff);
    send_interval(32'sd90000, 32'sd100000);
    wait_drained();
    write_reg(CFG_TOL, 32'h7fff_ffff);
    write_reg(CFG_ITER, 32'd64);
    send_interval(32'sh8000_0000, 32'sh7fff_ffff);
    send_interval(-32'sd196608, 32'sd655360);
    wait_drained();
    write_reg(CFG_TOL, 32'd655);
  endtask

  task automatic test_coefficient_extremes();
    write_reg(CFG_QUAD, 32'd0);
    write_reg(CFG_LIN, 32'd65536);
    write_reg(CFG_CONST, 32'h8000_0000);
    send_interval(-32'sd655360, 32'sd655360);
    wait_drained();
    write_reg(CFG_QUAD, 32'h8000_0000);
    write_reg(CFG_LIN, 32'h7fff_ffff);
    write_reg(CFG_CONST, 32'h7fff_ffff);
    send_interval(32'sh8000_0000, 32'sh7fff_ffff);
    wait_drained();
    write_reg(CFG_QUAD, 32'h7fff_ffff);
    write_reg(CFG_LIN, 32'h8000_0000);
    send_interval(-32'sd1000000, 32'sd3000000);
    wait_drained();
    write_reg(CFG_QUAD, -32'sd131072);
    write_reg(CFG_LIN, 32'd0);
    send_interval(-32'sd196608, 32'sd655360);
    wait_drained();
    write_reg(CFG_QUAD, 32'd0);
    send_interval(32'sd1000, -32'sd5000);
    wait_drained();
  endtask

  task automatic test_random_searches();
    int unsigned        item_count;
    logic signed [31:0] left, right;
    for (int phase = 0; phase < 14; phase++) begin
      randomize_objective(item_count);
      steady <= (phase == 4);
      for (int k = 0; k < item_count; k++) begin
        random_interval(left, right);
        send_interval(left, right);
        if (phase == 7 && k == 20) wait_drained();
      end
      wait_drained();
    end
    steady <= 1'b0;
  endtask

  task automatic test_output_backpressure();
    logic signed [31:0] left, right;
    write_reg(CFG_TOL, 32'd0);
    write_reg(CFG_ITER, 32'd16);
    hold_token <= hold_token + 8'd1;
    for (int k = 0; k < 24; k++) begin
      random_interval(left, right);
      send_interval(left, right);
    end
    wait_drained();
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_default_objective();
    test_step_limits();
    test_coefficient_extremes();
    test_random_searches();
    test_output_backpressure();
    wait_drained();
    repeat (2 * obj_iter + 8) @(posedge clk);
    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

@@ sim.f @@
hdl/gsm_pkg.sv
hdl/gsm_cfg.sv
hdl/gsm_ctrl.sv
hdl/gsm_dp.sv
hdl/golden_section_minimizer_top.sv
tb/tb_golden_section_minimizer_top.sv
